// ----- hdl/prtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_pkg
// shared types and constants for the pending request timeout table
// ----------------------------------------------------------------------------
package prtt_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W = 4;
    localparam logic [31:0] DEFAULT_TIMEOUT_RESET = 32'd5000;

    typedef enum logic [1:0] {
        OP_ISSUE  = 2'd0,
        OP_RESP   = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_CANCEL = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        OC_ISSUED  = 3'd0,
        OC_FULL    = 3'd1,
        OC_SUCCESS = 3'd2,
        OC_TIMEOUT = 3'd3,
        OC_CANCEL  = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic        active;
        logic [31:0] id;
        logic [31:0] deadline;
        logic [15:0] tag;
    } slot_entry_t;

endpackage

// ----- hdl/pending_request_timeout_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_request_timeout_table
// outstanding request table with deadlines, held in a rotating ring of cells
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  cfg       cfg_we                cfg_wdata (default timeout)
//  in        in_valid / in_ready   opcode, req_id, req_timeout, caller_tag, now_ms
//  out       out_valid / out_ready outcome, slot, out_id, out_tag, last
//
//  in a transaction the ring rotates once past the
//  single comparator at its head, then the held result is flushed
//  in_ready is high only between transactions
//  results stall the ring only when a second result meets a full output
//  register; after reset all slots are free, no clearing pass
// ----------------------------------------------------------------------------
module pending_request_timeout_table #(
    parameter int SLOTS = prtt_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] req_id,
    input  logic [31:0] req_timeout,
    input  logic [15:0] caller_tag,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  outcome,
    output logic [2:0]  slot,
    output logic [31:0] out_id,
    output logic [15:0] out_tag,
    output logic        last
);

    prtt_pkg::slot_entry_t ring_q [SLOTS];
    prtt_pkg::slot_entry_t tail;
    logic                  shift_en;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            prtt_pkg::slot_entry_t d;
            if (g == SLOTS - 1)
            begin : g_tail
                assign d = tail;
            end
            else
            begin : g_mid
                assign d = ring_q[g + 1];
            end

            prtt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (d),
                .q        (ring_q[g])
            );
        end
    endgenerate

    prtt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .req_id      (req_id),
        .req_timeout (req_timeout),
        .caller_tag  (caller_tag),
        .now_ms      (now_ms),
        .head        (ring_q[0]),
        .tail        (tail),
        .shift_en    (shift_en),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .outcome     (outcome),
        .slot        (slot),
        .out_id      (out_id),
        .out_tag     (out_tag),
        .last        (last)
    );

endmodule

// ----- hdl/prtt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_cell
// one table entry in the rotating ring, loads its neighbour on each shift
// ----------------------------------------------------------------------------
module prtt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  prtt_pkg::slot_entry_t d,
    output prtt_pkg::slot_entry_t q
);

    logic        active_reg;
    logic [31:0] id_reg;
    logic [31:0] deadline_reg;
    logic [15:0] tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            active_reg <= d.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            id_reg       <= d.id;
            deadline_reg <= d.deadline;
            tag_reg      <= d.tag;
        end
    end

    assign q.active   = active_reg;
    assign q.id       = id_reg;
    assign q.deadline = deadline_reg;
    assign q.tag      = tag_reg;

endmodule

// ----- hdl/prtt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtt_ctrl
// head-of-ring sequencer: checks one entry per cycle unless a result stalls the ring, and builds the results
// ----------------------------------------------------------------------------
module prtt_ctrl #(
    parameter int SLOTS = prtt_pkg::SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [31:0]           cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [31:0]           req_id,
    input  logic [31:0]           req_timeout,
    input  logic [15:0]           caller_tag,
    input  logic [31:0]           now_ms,
    input  prtt_pkg::slot_entry_t head,
    output prtt_pkg::slot_entry_t tail,
    output logic                  shift_en,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            outcome,
    output logic [2:0]            slot,
    output logic [31:0]           out_id,
    output logic [15:0]           out_tag,
    output logic                  last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    prtt_pkg::state_t      state_reg, state_next;
    prtt_pkg::opcode_t     op_reg, op_next;
    logic [31:0]           dflt_reg, dflt_next;
    logic [31:0]           id_reg, id_next;
    logic [15:0]           tag_reg, tag_next;
    logic [31:0]           now_reg, now_next;
    logic [31:0]           dl_reg, dl_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  done_reg, done_next;
    logic [prtt_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic                  pend_valid_reg, pend_valid_next;
    prtt_pkg::outcome_t    pend_oc_reg, pend_oc_next;
    logic [2:0]            pend_slot_reg, pend_slot_next;
    logic [31:0]           pend_id_reg, pend_id_next;
    logic [15:0]           pend_tag_reg, pend_tag_next;

    logic                  out_valid_reg, out_valid_next;
    prtt_pkg::outcome_t    out_oc_reg, out_oc_next;
    logic [2:0]            out_slot_reg, out_slot_next;
    logic [31:0]           out_id_reg, out_id_next;
    logic [15:0]           out_tag_reg, out_tag_next;
    logic                  out_last_reg, out_last_next;

    logic                  reached;
    logic                  hit;
    logic                  out_free;
    logic                  room;
    prtt_pkg::outcome_t    hit_oc;
    logic [31:0]           wrap_diff;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= prtt_pkg::ST_IDLE;
            dflt_reg       <= prtt_pkg::DEFAULT_TIMEOUT_RESET;
            idx_reg        <= '0;
            done_reg       <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dflt_reg       <= dflt_next;
            idx_reg        <= idx_next;
            done_reg       <= done_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        tag_reg       <= tag_next;
        now_reg       <= now_next;
        dl_reg        <= dl_next;
        pend_oc_reg   <= pend_oc_next;
        pend_slot_reg <= pend_slot_next;
        pend_id_reg   <= pend_id_next;
        pend_tag_reg  <= pend_tag_next;
        out_oc_reg    <= out_oc_next;
        out_slot_reg  <= out_slot_next;
        out_id_reg    <= out_id_next;
        out_tag_reg   <= out_tag_next;
        out_last_reg  <= out_last_next;
    end

    // signed wrap difference, deadline reached when non-negative
    assign wrap_diff = now_reg - head.deadline;
    assign reached   = ~wrap_diff[31];
    assign out_free  = !out_valid_reg || out_ready;
    assign room      = (cnt_reg < prtt_pkg::CNT_W'(prtt_pkg::MAX_RESULTS));

    always_comb
    begin
        hit    = 1'b0;
        hit_oc = prtt_pkg::OC_ISSUED;
        tail   = head;
        case (op_reg)
            prtt_pkg::OP_ISSUE:
            begin
                if (!done_reg && !head.active)
                begin
                    hit           = 1'b1;
                    hit_oc        = prtt_pkg::OC_ISSUED;
                    tail.active   = 1'b1;
                    tail.id       = id_reg;
                    tail.deadline = dl_reg;
                    tail.tag      = tag_reg;
                end
            end
            prtt_pkg::OP_RESP:
            begin
                if (!done_reg && head.active && head.id == id_reg)
                begin
                    hit         = 1'b1;
                    hit_oc      = reached ? prtt_pkg::OC_TIMEOUT : prtt_pkg::OC_SUCCESS;
                    tail.active = 1'b0;
                end
            end
            prtt_pkg::OP_SWEEP:
            begin
                if (head.active && reached && room)
                begin
                    hit         = 1'b1;
                    hit_oc      = prtt_pkg::OC_TIMEOUT;
                    tail.active = 1'b0;
                end
            end
            prtt_pkg::OP_CANCEL:
            begin
                if (head.active && room)
                begin
                    hit         = 1'b1;
                    hit_oc      = prtt_pkg::OC_CANCEL;
                    tail.active = 1'b0;
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        dflt_next       = dflt_reg;
        id_next         = id_reg;
        tag_next        = tag_reg;
        now_next        = now_reg;
        dl_next         = dl_reg;
        idx_next        = idx_reg;
        done_next       = done_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_oc_next    = pend_oc_reg;
        pend_slot_next  = pend_slot_reg;
        pend_id_next    = pend_id_reg;
        pend_tag_next   = pend_tag_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_oc_next     = out_oc_reg;
        out_slot_next   = out_slot_reg;
        out_id_next     = out_id_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        in_ready        = 1'b0;
        shift_en        = 1'b0;

        if (cfg_we)
        begin
            dflt_next = cfg_wdata;
        end

        case (state_reg)
            prtt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = prtt_pkg::opcode_t'(opcode);
                    id_next    = req_id;
                    tag_next   = caller_tag;
                    now_next   = now_ms;
                    dl_next    = now_ms + ((req_timeout != 32'd0) ? req_timeout : dflt_reg);
                    idx_next   = '0;
                    done_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = prtt_pkg::ST_WALK;
                end
            end
            prtt_pkg::ST_WALK:
            begin
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    shift_en = 1'b1;
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_oc_next    = pend_oc_reg;
                            out_slot_next  = pend_slot_reg;
                            out_id_next    = pend_id_reg;
                            out_tag_next   = pend_tag_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_oc_next    = hit_oc;
                        pend_slot_next  = 3'(idx_reg);
                        pend_id_next    = tail.id;
                        pend_tag_next   = tail.tag;
                        done_next       = 1'b1;
                        cnt_next        = cnt_reg + prtt_pkg::CNT_W'(1);
                    end
                    if (idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        idx_next   = '0;
                        state_next = prtt_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            prtt_pkg::ST_FLUSH:
            begin
                if (op_reg == prtt_pkg::OP_ISSUE && !done_reg)
                begin
                    // table full
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_oc_next    = prtt_pkg::OC_FULL;
                        out_slot_next  = 3'd0;
                        out_id_next    = id_reg;
                        out_tag_next   = tag_reg;
                        out_last_next  = 1'b1;
                        state_next     = prtt_pkg::ST_IDLE;
                    end
                end
                else if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_oc_next     = pend_oc_reg;
                        out_slot_next   = pend_slot_reg;
                        out_id_next     = pend_id_reg;
                        out_tag_next    = pend_tag_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = prtt_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = prtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prtt_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign outcome   = out_oc_reg;
    assign slot      = out_slot_reg;
    assign out_id    = out_id_reg;
    assign out_tag   = out_tag_reg;
    assign last      = out_last_reg;

endmodule

// ----- tb/pending_request_timeout_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_request_timeout_table_test
// drives issue, response, sweep and cancel transactions into the request table
// and checks every completion, field by field, in order, against a behavioural
// table copy kept in the bench or, for typed rows, the typed-in outcome; a table
// of directed rows comes first, then random traffic under changing back-pressure
// ----------------------------------------------------------------------------
module pending_request_timeout_table_test;

    import prtt_pkg::*;

    localparam int SLOTS = SLOTS_DEFAULT;
    localparam int DRAIN_LIMIT = 4000;
    localparam int SETTLE_CYCLES = SLOTS + 6;
    localparam int RANDOM_PER_PHASE = 80;

    typedef enum bit {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        opcode_t     op;
        logic [31:0] id;
        logic [31:0] tmo;
        logic [15:0] tag;
        logic [31:0] now;
    } request_t;

    typedef struct packed {
        outcome_t    outcome;
        logic [2:0]  slot;
        logic [31:0] id;
        logic [15:0] tag;
        logic        last;
    } completion_t;

    // for configuration rows the register value sits in the timeout column
    typedef struct packed {
        row_kind_t   kind;
        opcode_t     op;
        logic [31:0] id;
        logic [31:0] tmo;
        logic [15:0] tag;
        logic [31:0] now;
        logic        typed;
        outcome_t    want;
        logic [2:0]  want_slot;
    } directed_row_t;

    localparam directed_row_t DIRECTED [26] = '{
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0000, 32'd100,       16'h0000, 32'd0,
          1'b1, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_ISSUE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
          1'b1, OC_ISSUED, 3'd1},
        '{ROW_ITEM, OP_ISSUE,  32'hA5A5_0001, 32'd0,         16'h1234, 32'd10,
          1'b1, OC_ISSUED, 3'd2},
        '{ROW_ITEM, OP_RESP,   32'h0000_0000, 32'd0,         16'h0000, 32'd50,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_RESP,   32'h1234_5678, 32'd0,         16'h0000, 32'd60,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_RESP,   32'hA5A5_0001, 32'd0,         16'h0000, 32'd5010,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0100, 32'd10,        16'h0001, 32'd6000,
          1'b1, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0101, 32'd20,        16'h0002, 32'd6000,
          1'b1, OC_ISSUED, 3'd2},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0102, 32'd30,        16'h0003, 32'd6000,
          1'b1, OC_ISSUED, 3'd3},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0103, 32'd40,        16'h0004, 32'd6000,
          1'b1, OC_ISSUED, 3'd4},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0104, 32'd50,        16'h0005, 32'd6000,
          1'b1, OC_ISSUED, 3'd5},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0105, 32'd60,        16'h0006, 32'd6000,
          1'b1, OC_ISSUED, 3'd6},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0106, 32'd70,        16'h0007, 32'd6000,
          1'b1, OC_ISSUED, 3'd7},
        '{ROW_ITEM, OP_ISSUE,  32'hDEAD_BEEF, 32'd1,         16'hBEEF, 32'd6000,
          1'b1, OC_FULL,   3'd0},
        '{ROW_ITEM, OP_SWEEP,  32'h0000_0000, 32'd0,         16'h0000, 32'd6035,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_CANCEL, 32'h0000_0000, 32'd0,         16'h0000, 32'd6040,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_SWEEP,  32'h0000_0000, 32'd0,         16'h0000, 32'd6050,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_CFG,  OP_ISSUE,  32'h0000_0000, 32'd0,         16'h0000, 32'd0,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0055, 32'd0,         16'h5555, 32'd7000,
          1'b1, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_RESP,   32'h0000_0055, 32'd0,         16'h0000, 32'd7000,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_CFG,  OP_ISSUE,  32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, 32'd0,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0077, 32'd0,         16'h7777, 32'hFFFF_FFF0,
          1'b1, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_ISSUE,  32'h0000_0077, 32'h20,        16'h7778, 32'hFFFF_FFF0,
          1'b1, OC_ISSUED, 3'd1},
        '{ROW_ITEM, OP_RESP,   32'h0000_0077, 32'd0,         16'h0000, 32'd8,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_SWEEP,  32'h0000_0000, 32'd0,         16'h0000, 32'd8,
          1'b0, OC_ISSUED, 3'd0},
        '{ROW_ITEM, OP_CANCEL, 32'h0000_0000, 32'd0,         16'h0000, 32'd9,
          1'b0, OC_ISSUED, 3'd0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [31:0] req_id;
    logic [31:0] req_timeout;
    logic [15:0] caller_tag;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  outcome;
    logic [2:0]  slot;
    logic [31:0] out_id;
    logic [15:0] out_tag;
    logic        last;

    // bench copy of the table
    logic [31:0] default_tmo;
    bit          held_active [SLOTS];
    logic [31:0] held_id [SLOTS];
    logic [31:0] held_deadline [SLOTS];
    logic [15:0] held_tag [SLOTS];

    completion_t awaited [$];
    int          failures = 0;
    int          send_idle_pct = 23;
    int          recv_idle_pct = 51;
    logic [31:0] clock_ms;

    pending_request_timeout_table #(
        .SLOTS(SLOTS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .req_id     (req_id),
        .req_timeout(req_timeout),
        .caller_tag (caller_tag),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .outcome    (outcome),
        .slot       (slot),
        .out_id     (out_id),
        .out_tag    (out_tag),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic bit deadline_reached(input logic [31:0] now, input logic [31:0] dl);
        logic [31:0] diff;
        diff = now - dl;
        return !diff[31];
    endfunction

    function automatic logic [31:0] pick_id();
        return ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(15));
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // applies one accepted transaction to the bench table
    task automatic update_table(input request_t r, input bit emit);
        completion_t found [$];
        outcome_t    oc;
        int          i;
        found.delete();
        case (r.op)
            OP_ISSUE:
            begin
                i = 0;
                while (i < SLOTS && held_active[i])
                    i++;
                if (i == SLOTS)
                    found.push_back(completion_t'{OC_FULL, 3'd0, r.id, r.tag, 1'b0});
                else
                begin
                    held_active[i] = 1'b1;
                    held_id[i] = r.id;
                    held_tag[i] = r.tag;
                    held_deadline[i] = r.now + ((r.tmo != 0) ? r.tmo : default_tmo);
                    found.push_back(completion_t'{OC_ISSUED, 3'(i), r.id, r.tag, 1'b0});
                end
            end
            OP_RESP:
            begin
                i = 0;
                while (i < SLOTS && !(held_active[i] && held_id[i] == r.id))
                    i++;
                if (i < SLOTS)
                begin
                    held_active[i] = 1'b0;
                    oc = deadline_reached(r.now, held_deadline[i]) ? OC_TIMEOUT : OC_SUCCESS;
                    found.push_back(completion_t'{oc, 3'(i), held_id[i], held_tag[i], 1'b0});
                end
            end
            default:
            begin
                oc = (r.op == OP_SWEEP) ? OC_TIMEOUT : OC_CANCEL;
                for (i = 0; i < SLOTS && found.size() < MAX_RESULTS; i++)
                begin
                    if (held_active[i] &&
                        (r.op == OP_CANCEL || deadline_reached(r.now, held_deadline[i])))
                    begin
                        held_active[i] = 1'b0;
                        found.push_back(completion_t'{oc, 3'(i), held_id[i], held_tag[i],
                                                      1'b0});
                    end
                end
            end
        endcase
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        if (emit)
            foreach (found[k])
                awaited.push_back(found[k]);
    endtask

    task automatic offer_request(input request_t r, input bit emit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= r.op;
        req_id      <= r.id;
        req_timeout <= r.tmo;
        caller_tag  <= r.tag;
        now_ms      <= r.now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid <= 1'b0;
        update_table(r, emit);
        @(posedge clk);
    endtask

    task automatic pause_until_drained();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (awaited.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (awaited.size() != 0)
        begin
            $error("%0d completions never arrived", awaited.size());
            failures++;
            awaited.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_default_timeout(input logic [31:0] value);
        pause_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        default_tmo = value;
    endtask

    task automatic random_request();
        request_t r;
        int       live [$];
        int       roll;
        clock_ms += ($urandom_range(49) == 0) ? 32'($urandom) : 32'($urandom_range(60));
        r.id  = pick_id();
        r.tmo = $urandom;
        r.tag = 16'($urandom);
        r.now = clock_ms;
        roll  = $urandom_range(99);
        if (roll < 45)
        begin
            r.op = OP_ISSUE;
            case ($urandom_range(9))
                0, 1: r.tmo = 32'd0;
                2: r.tmo = $urandom;
                default: r.tmo = $urandom_range(1, 300);
            endcase
        end
        else if (roll < 80)
        begin
            r.op = OP_RESP;
            for (int i = 0; i < SLOTS; i++)
                if (held_active[i])
                    live.push_back(i);
            if (live.size() != 0 && $urandom_range(99) < 80)
                r.id = held_id[live[$urandom_range(live.size() - 1)]];
        end
        else if (roll < 95)
            r.op = OP_SWEEP;
        else
            r.op = OP_CANCEL;
        offer_request(r, 1'b1);
    endtask

    // completion checker
    always @(posedge clk)
    begin
        completion_t c;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited.size() == 0)
            begin
                $error("completion with nothing awaited: outcome %0d slot %0d id 0x%0h",
                       outcome, slot, out_id);
                failures++;
            end
            else
            begin
                c = awaited.pop_front();
                compare_field("outcome", 32'(c.outcome), 32'(outcome));
                compare_field("slot", 32'(c.slot), 32'(slot));
                compare_field("out_id", c.id, out_id);
                compare_field("out_tag", 32'(c.tag), 32'(out_tag));
                compare_field("last", 32'(c.last), 32'(last));
            end
        end
    end

    initial
    begin
        request_t    r;
        logic [31:0] phase_tmo [3];
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 32'd0;
        in_valid    = 1'b0;
        opcode      = OP_ISSUE;
        req_id      = 32'd0;
        req_timeout = 32'd0;
        caller_tag  = 16'd0;
        now_ms      = 32'd0;
        default_tmo = DEFAULT_TIMEOUT_RESET;
        foreach (held_active[i])
            held_active[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                write_default_timeout(DIRECTED[i].tmo);
            else
            begin
                r = '{DIRECTED[i].op, DIRECTED[i].id, DIRECTED[i].tmo, DIRECTED[i].tag,
                      DIRECTED[i].now};
                offer_request(r, !DIRECTED[i].typed);
                if (DIRECTED[i].typed)
                    awaited.push_back(completion_t'{DIRECTED[i].want, DIRECTED[i].want_slot,
                                                   r.id, r.tag, 1'b1});
            end
        end

        phase_tmo[0] = 32'd1;
        phase_tmo[1] = 32'h8000_0000;
        phase_tmo[2] = $urandom_range(20, 400);
        clock_ms = $urandom;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 23 : 0;
            write_default_timeout(phase_tmo[phase]);
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                // hold off the sender until the table has answered everything
                if (k == RANDOM_PER_PHASE / 2)
                    pause_until_drained();
                random_request();
            end
        end

        pause_until_drained();
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
